@@ design/bdh_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types, widths and codes for the button debounce / hold block.
// ----------------------------------------------------------------------------
package bdh_pkg;

  localparam int unsigned NOW_W         = 32;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned DELAY_W       = 16;
  localparam int unsigned STICKY_W      = 32;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam logic [DELAY_W-1:0]  DELAY_RST  = DELAY_W'(50);
  localparam logic [STICKY_W-1:0] STICKY_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 1'b0,
    CFG_STICKY   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_RESET = 3'd0,
    PH_START = 3'd1,
    PH_GO    = 3'd2,
    PH_WAIT  = 3'd3,
    PH_TRIG  = 3'd4,
    PH_HELD  = 3'd5,
    PH_REL   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [DELAY_W-1:0]  debounce_delay_ms;
    logic [STICKY_W-1:0] sticky_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic sticky;
    logic released;
    logic held;
    logic pressed;
  } flags_t;

  typedef struct packed {
    logic             pressed;
    logic             held;
    logic             released;
    logic             sticky_held;
    logic [OUT_W-1:0] hold_time_ms;
    logic [OUT_W-1:0] sticky_remaining_ms;
  } result_t;

endpackage
`default_nettype wire

@@ design/bdh_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdh_in_if
// Poll channel: button level and millisecond timestamp, valid/ready.
// ----------------------------------------------------------------------------
interface bdh_in_if import bdh_pkg::*;;
  logic             valid;
  logic             ready;
  logic             button_level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, output button_level, output now_ms, input ready);
  modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface
`default_nettype wire

@@ design/bdh_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdh_out_if
// Result channel: event flags and timer values, valid/ready.
// ----------------------------------------------------------------------------
interface bdh_out_if import bdh_pkg::*;;
  logic             valid;
  logic             ready;
  logic             pressed;
  logic             held;
  logic             released;
  logic             sticky_held;
  logic [OUT_W-1:0] hold_time_ms;
  logic [OUT_W-1:0] sticky_remaining_ms;

  modport source (output valid, output pressed, output held, output released,
                  output sticky_held, output hold_time_ms,
                  output sticky_remaining_ms, input ready);
  modport sink   (input valid, input pressed, input held, input released,
                  input sticky_held, input hold_time_ms,
                  input sticky_remaining_ms, output ready);
endinterface
`default_nettype wire

@@ design/bdh_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdh_cfg
// Configuration registers: debounce delay and sticky hold duration.
// ----------------------------------------------------------------------------
module bdh_cfg import bdh_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_delay_ms <= DELAY_RST;
      cfg_q.sticky_hold_ms    <= STICKY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE: cfg_q.debounce_delay_ms <= cfg_data_i[DELAY_W-1:0];
        CFG_STICKY:   cfg_q.sticky_hold_ms    <= cfg_data_i[STICKY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/bdh_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdh_fsm
// Phase machine, timer start stamps and event flags; one step per poll.
// ----------------------------------------------------------------------------
module bdh_fsm import bdh_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             level_i,
  input  wire logic [NOW_W-1:0] now_i,
  input  cfg_t                  cfg_i,
  output result_t               res_o
);

  // compare width: at least as wide as the outputs and the sticky duration
  localparam int unsigned CW = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;

  phase_e                phase_q, phase_d;
  flags_t                flags_q, flags_d;
  logic [TIME_BITS-1:0]  db_start_q, db_start_d;
  logic [TIME_BITS-1:0]  st_start_q, st_start_d;
  logic [TIME_BITS-1:0]  hd_start_q, hd_start_d;

  logic [TIME_BITS-1:0]  now_t;
  logic [CW-1:0]         st_el_old, db_el, hd_el, st_el_new, st_dur, db_dur, st_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RESET;
      flags_q    <= '0;
      db_start_q <= '0;
      st_start_q <= '0;
      hd_start_q <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      flags_q    <= flags_d;
      db_start_q <= db_start_d;
      st_start_q <= st_start_d;
      hd_start_q <= hd_start_d;
    end
  end

  always_comb begin
    now_t      = TIME_BITS'(now_i);
    st_dur     = CW'(cfg_i.sticky_hold_ms);
    db_dur     = CW'(cfg_i.debounce_delay_ms);
    st_el_old  = CW'(TIME_BITS'(now_t - st_start_q));
    db_el      = CW'(TIME_BITS'(now_t - db_start_q));

    phase_d    = phase_q;
    flags_d    = flags_q;
    db_start_d = db_start_q;
    st_start_d = st_start_q;
    hd_start_d = hd_start_q;

    // sticky timer expiry is checked against the stamp before this poll
    if (st_el_old >= st_dur) flags_d.sticky = 1'b0;

    case (phase_q)
      PH_START: phase_d = level_i ? PH_RESET : PH_GO;
      PH_GO: begin
        db_start_d = now_t;
        phase_d    = PH_WAIT;
      end
      PH_WAIT: begin
        if (level_i)              phase_d = PH_RESET;
        else if (db_el >= db_dur) phase_d = PH_TRIG;
      end
      PH_TRIG: begin
        phase_d         = PH_HELD;
        flags_d.pressed = 1'b1;
        flags_d.sticky  = 1'b1;
        hd_start_d      = now_t;
        st_start_d      = now_t;
      end
      PH_HELD: begin
        flags_d.pressed = 1'b0;
        flags_d.held    = 1'b1;
        if (level_i) phase_d = PH_REL;
      end
      PH_REL: begin
        flags_d.held     = 1'b0;
        flags_d.released = 1'b1;
        phase_d          = PH_RESET;
      end
      default: begin
        // reset phase, and the unused code: keep only the sticky flag
        flags_d.pressed  = 1'b0;
        flags_d.held     = 1'b0;
        flags_d.released = 1'b0;
        hd_start_d       = now_t;
        phase_d          = PH_START;
      end
    endcase

    hd_el     = CW'(TIME_BITS'(now_t - hd_start_d));
    st_el_new = CW'(TIME_BITS'(now_t - st_start_d));
    st_rem    = (st_el_new >= st_dur) ? '0 : (st_dur - st_el_new);

    res_o.pressed             = flags_d.pressed;
    res_o.held                = flags_d.held;
    res_o.released            = flags_d.released;
    res_o.sticky_held         = flags_d.sticky;
    res_o.hold_time_ms        = hd_el[OUT_W-1:0];
    res_o.sticky_remaining_ms = st_rem[OUT_W-1:0];
  end

  // pressed pulse only ever stands while the machine sits in held
  a_pressed_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.pressed |-> phase_q == PH_HELD)
    else $error("pressed flag outside held phase");

  a_held_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.held |-> (phase_q == PH_HELD || phase_q == PH_REL))
    else $error("held flag outside held/released phases");

  a_released_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.released |-> phase_q == PH_RESET)
    else $error("released flag outside reset phase");

  a_trig_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_TRIG) |-> $past(phase_q) == PH_WAIT)
    else $error("triggered phase entered from other than wait");

endmodule
`default_nettype wire

@@ design/button_debounce_hold_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_hold_fsm
// Debounced push-button machine with press/release pulses and hold timers.
// ----------------------------------------------------------------------------
// Each input item is one poll of an active-low button pin together with a
// free-running millisecond timestamp; each poll yields exactly one result item.
// A poll is captured in an input register. Once the result slot is empty or
// being drained, the phase machine steps on the registered poll and the
// result register loads, and one poll per clock is sustained while the
// result side takes every item. The input register and result register
// form a two-deep pipeline: while a result waits on the output, one more poll
// can be taken into the input register, and after that the poll channel
// stalls until the waiting result is taken. Timer state is TIME_BITS wide and
// all time differences wrap at that width; result times are the low 32 bits.
// Configuration (index 0: debounce delay, index 1: sticky hold duration)
// should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module button_debounce_hold_fsm import bdh_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bdh_in_if.sink                     in_i,
  bdh_out_if.source                  out_o
);

  cfg_t             cfg;
  result_t          res, res_q;

  // input register
  logic             s1_valid_q;
  logic             s1_level_q;
  logic [NOW_W-1:0] s1_now_q;

  // result register
  logic             o_valid_q;

  logic             in_acc;
  logic             load_out;

  // the stage-1 item moves on when the result slot is empty or being drained
  assign load_out   = s1_valid_q && (!o_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || load_out;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (in_acc)        s1_valid_q <= 1'b1;
      else if (load_out) s1_valid_q <= 1'b0;

      if (load_out)         o_valid_q <= 1'b1;
      else if (out_o.ready) o_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_level_q <= in_i.button_level;
      s1_now_q   <= in_i.now_ms;
    end
    if (load_out) res_q <= res;
  end

  bdh_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // state advances exactly when a result is loaded
  bdh_fsm #(
    .TIME_BITS (TIME_BITS)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (load_out),
    .level_i (s1_level_q),
    .now_i   (s1_now_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_o.valid               = o_valid_q;
  assign out_o.pressed             = res_q.pressed;
  assign out_o.held                = res_q.held;
  assign out_o.released            = res_q.released;
  assign out_o.sticky_held         = res_q.sticky_held;
  assign out_o.hold_time_ms        = res_q.hold_time_ms;
  assign out_o.sticky_remaining_ms = res_q.sticky_remaining_ms;

endmodule
`default_nettype wire

@@ sim/bdh_poll_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdh_poll_checker
// Watches the poll and result channels of the debounce block and the register
// write port. It keeps its own copy of the phase machine and timers, works out
// the result of every accepted poll, and compares each accepted result field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bdh_poll_checker import bdh_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bdh_in_if                          in_ch,
  bdh_out_if                         out_ch,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o,
  output int unsigned                n_checked_o,
  output int unsigned                n_press_o,
  output int unsigned                n_release_o
);

  // shadow registers
  logic [DELAY_W-1:0]  delay_ms;
  logic [STICKY_W-1:0] sticky_ms;

  // shadow machine state
  phase_e           phase;
  logic [NOW_W-1:0] debounce_t0;
  logic [NOW_W-1:0] sticky_t0;
  logic [NOW_W-1:0] hold_t0;
  flags_t           ev;

  result_t     poll_results_q[$];
  int unsigned fail_cnt    = 0;
  int unsigned n_checked   = 0;
  int unsigned n_press     = 0;
  int unsigned n_release   = 0;
  int unsigned pending_cnt = 0;

  assign fail_cnt_o  = fail_cnt;
  assign pending_o   = pending_cnt;
  assign n_checked_o = n_checked;
  assign n_press_o   = n_press;
  assign n_release_o = n_release;

  // One poll through the machine; state is updated in place.
  function automatic result_t next_poll_result(input logic lvl, input logic [NOW_W-1:0] now);
    result_t          r;
    logic [NOW_W-1:0] since_press;
    // sticky expiry is looked at before the phase step
    if (NOW_W'(now - sticky_t0) >= sticky_ms) ev.sticky = 1'b0;
    case (phase)
      PH_START: phase = lvl ? PH_RESET : PH_GO;
      PH_GO: begin
        debounce_t0 = now;
        phase       = PH_WAIT;
      end
      PH_WAIT: begin
        if (lvl) phase = PH_RESET;
        else if (NOW_W'(now - debounce_t0) >= NOW_W'(delay_ms)) phase = PH_TRIG;
      end
      PH_TRIG: begin
        phase      = PH_HELD;
        ev.pressed = 1'b1;
        ev.sticky  = 1'b1;
        hold_t0    = now;
        sticky_t0  = now;
      end
      PH_HELD: begin
        ev.pressed = 1'b0;
        ev.held    = 1'b1;
        if (lvl) phase = PH_REL;
      end
      PH_REL: begin
        ev.held     = 1'b0;
        ev.released = 1'b1;
        phase       = PH_RESET;
      end
      default: begin
        ev      = '{sticky: ev.sticky, released: 1'b0, held: 1'b0, pressed: 1'b0};
        hold_t0 = now;
        phase   = PH_START;
      end
    endcase
    since_press           = now - sticky_t0;
    r.pressed             = ev.pressed;
    r.held                = ev.held;
    r.released            = ev.released;
    r.sticky_held         = ev.sticky;
    r.hold_time_ms        = now - hold_t0;
    r.sticky_remaining_ms = (since_press >= sticky_ms) ? '0 : OUT_W'(sticky_ms - since_press);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      delay_ms    = DELAY_RST;
      sticky_ms   = STICKY_RST;
      phase       = PH_RESET;
      debounce_t0 = '0;
      sticky_t0   = '0;
      hold_t0     = '0;
      ev          = '0;
      poll_results_q.delete();
      pending_cnt <= 0;
    end else begin
      // results leave before this edge's poll can add its own
      if (out_ch.valid && out_ch.ready) begin
        got = '{pressed: out_ch.pressed, held: out_ch.held, released: out_ch.released,
                sticky_held: out_ch.sticky_held, hold_time_ms: out_ch.hold_time_ms,
                sticky_remaining_ms: out_ch.sticky_remaining_ms};
        if (poll_results_q.size() == 0) begin
          $error("result item with no poll outstanding");
          fail_cnt++;
        end else begin
          want = poll_results_q.pop_front();
          check_field("pressed", OUT_W'(want.pressed), OUT_W'(got.pressed));
          check_field("held", OUT_W'(want.held), OUT_W'(got.held));
          check_field("released", OUT_W'(want.released), OUT_W'(got.released));
          check_field("sticky_held", OUT_W'(want.sticky_held), OUT_W'(got.sticky_held));
          check_field("hold_time_ms", want.hold_time_ms, got.hold_time_ms);
          check_field("sticky_remaining_ms", want.sticky_remaining_ms,
                      got.sticky_remaining_ms);
          n_checked++;
          if (got.pressed) n_press++;
          if (got.released) n_release++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE: delay_ms  = cfg_data_i[DELAY_W-1:0];
          CFG_STICKY:   sticky_ms = cfg_data_i[STICKY_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        poll_results_q.push_back(next_poll_result(in_ch.button_level, in_ch.now_ms));
      pending_cnt <= poll_results_q.size();
    end
  end

endmodule

@@ sim/button_debounce_hold_fsm_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_hold_fsm_tb
// Stimulus and verdict for the debounced push-button machine.
// ----------------------------------------------------------------------------
// A short directed run walks every phase of the machine at the reset register
// values, crosses the timestamp wrap and rewrites the sticky duration mid-run.
// Then eight register settings follow, each with random press episodes
// (a few high polls, a low run with occasional bounce, a release), some pure
// noise, and timestamps that mostly creep but sometimes jump. Sender idling
// and receiver stalls rotate per setting. bdh_poll_checker does all
// prediction and comparison; this module only drives and reports.
// ----------------------------------------------------------------------------
module button_debounce_hold_fsm_tb;
  import bdh_pkg::*;

  localparam int          CLK_PERIOD     = 4;
  localparam int unsigned NUM_SETTINGS   = 8;
  localparam int unsigned SETTING_ITEMS  = 141;
  localparam int unsigned LONG_STALL     = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdh_in_if  in_ch ();
  bdh_out_if out_ch ();

  int unsigned fail_cnt, pending, n_checked, n_press, n_release;

  // pacing knobs shared by the sender and receiver processes
  int unsigned idle_pct       = 0;
  int unsigned stall_pct      = 0;
  bit          long_stall_req = 1'b0;

  logic [NOW_W-1:0] clock_ms;
  int unsigned      n_sent      = 0;
  int unsigned      idle_cycles = 0;

  // register settings per random section; extremes at index 0 and 2, with extreme sticky values also at 5 and 6
  logic [DELAY_W-1:0]  delay_set  [NUM_SETTINGS] = '{16'd0, 16'd3, 16'hFFFF, 16'd10,
                                                     16'd1, 16'd50, 16'd7, 16'd2};
  logic [STICKY_W-1:0] sticky_set [NUM_SETTINGS] = '{32'd0, 32'd40, 32'hFFFF_FFFF, 32'd1,
                                                     32'd100, 32'd0, 32'hFFFF_FFFF, 32'd25};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  button_debounce_hold_fsm dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  bdh_poll_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .n_checked_o (n_checked),
    .n_press_o   (n_press),
    .n_release_o (n_release)
  );

  // --------------------------------------------------------------------------
  // Result side: random stalls, or one long hold-off on request. The long
  // hold-off is counted here so the sender keeps offering polls meanwhile and
  // the two-deep pipeline fills and pushes back on the poll channel.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        long_stall_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles without any item moving ends the run.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // One poll item. Idle gaps come first so valid is never lowered and raised
  // in the same step; each idle cycle is entered and repeated with idle_pct percent odds.
  task automatic send_poll(input logic lvl, input logic [NOW_W-1:0] t);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_level <= lvl;
    in_ch.now_ms       <= t;
    do begin
      @(posedge clk_i);
    end while (!in_ch.ready);
    n_sent++;
  endtask

  // Stop offering and wait until every poll has its result back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  // Only called with the block idle. Waits for an edge with we low before returning so that
  // back-to-back writes never stack two assignments in one step.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small steps so debounce windows play out poll by poll; now and
  // then a medium step or a full random jump (which also exercises the wrap).
  task automatic poll_next(input logic lvl);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85)      clock_ms = clock_ms + $urandom_range(0, 4);
    else if (r < 95) clock_ms = clock_ms + $urandom_range(5, 300);
    else             clock_ms = clock_ms + $urandom;
    send_poll(lvl, clock_ms);
  endtask

  // A press episode: released lead-in, a low run with rare bounce, release.
  // Noisy episodes toggle the level at random throughout the low run.
  task automatic press_episode(input bit noisy);
    int unsigned n_lead, n_low, n_tail;
    n_lead = $urandom_range(0, 3);
    n_low  = $urandom_range(1, 14);
    n_tail = $urandom_range(1, 4);
    repeat (n_lead) poll_next(1'b1);
    repeat (n_low) poll_next(noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 6));
    repeat (n_tail) poll_next(1'b1);
  endtask

  initial begin
    int unsigned base;
    bit          mid_done;

    in_ch.valid        <= 1'b0;
    in_ch.button_level <= 1'b1;
    in_ch.now_ms       <= '0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_DEBOUNCE;
    cfg_data           <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: reset registers (debounce 50, sticky 0) -----------------
    send_poll(1'b1, 32'h0000_0000);   // reset -> start
    send_poll(1'b1, 32'h0000_0001);   // start, level high -> back to reset
    send_poll(1'b0, 32'h0000_0002);   // reset -> start
    send_poll(1'b0, 32'h0000_0003);   // start -> go
    send_poll(1'b0, 32'h0000_0004);   // go latches the debounce start
    send_poll(1'b0, 32'h0000_001E);   // waiting, short of the delay
    send_poll(1'b1, 32'h0000_001F);   // bounce high during wait -> reset
    send_poll(1'b0, 32'hFFFF_FFF0);   // restart just below the wrap
    send_poll(1'b0, 32'hFFFF_FFF1);
    send_poll(1'b0, 32'hFFFF_FFF2);   // debounce start near the top
    send_poll(1'b0, 32'h0000_0023);   // wrapped, still one short of the delay
    send_poll(1'b0, 32'h0000_0024);   // elapsed exactly the delay -> trigger
    send_poll(1'b0, 32'h0000_0025);   // pressed pulse, sticky set
    send_poll(1'b0, 32'h0000_0026);   // held; zero sticky expires at once
    send_poll(1'b0, 32'hFFFF_FFFF);   // held, large hold time
    send_poll(1'b1, 32'h0000_0030);   // release seen -> released phase
    send_poll(1'b1, 32'h0000_0031);   // released pulse
    send_poll(1'b1, 32'h0000_0032);   // back through reset
    // a sticky rewrite keeps the press time: remaining counts from that press
    drain();
    write_reg(CFG_STICKY, 32'd100);
    send_poll(1'b1, 32'h0000_0040);
    send_poll(1'b1, 32'h0000_0090);

    // ---- random sections, one per register setting ------------------------
    for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      write_reg(CFG_DEBOUNCE, CFG_DATA_W'(delay_set[s]));
      write_reg(CFG_STICKY, sticky_set[s]);
      // rotate: no idling, sender idle, receiver stall, both
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      clock_ms = (s == 3) ? 32'hFFFF_FF80 : $urandom;
      base     = n_sent;
      mid_done = 1'b0;
      while (n_sent - base < SETTING_ITEMS) begin
        if (!mid_done && (n_sent - base) >= SETTING_ITEMS / 2) begin
          mid_done = 1'b1;
          if (s == 4) long_stall_req = 1'b1;  // back-pressure with a full pipeline
          if (s == 5) drain();                // sender pauses until all results are in
        end
        press_episode($urandom_range(0, 99) < 10);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("%0d polls over %0d register settings: directed walk, wrap, press episodes,",
             n_sent, NUM_SETTINGS + 2);
    $display("noise, idle/stall mixes and a long hold-off; %0d results, %0d presses, %0d releases",
             n_checked, n_press, n_release);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bdh_pkg.sv
design/bdh_in_if.sv
design/bdh_out_if.sv
design/bdh_cfg.sv
design/bdh_fsm.sv
design/button_debounce_hold_fsm.sv
sim/bdh_poll_checker.sv
sim/button_debounce_hold_fsm_tb.sv
